### src/bbrw_pkg.sv
// Package for the bit buffer reader/writer: sizes, request codes and widths.
// Used by the channel interfaces and by the top level; no dependencies.
package bbrw_pkg;

   // store geometry
   localparam int STORE_BYTES    = 4096;
   localparam int MAX_FIELD_BITS = 32;
   localparam int BYTE_BITS      = 8;
   localparam int BYTE_MASK      = 7;
   localparam int CAP_BITS       = STORE_BYTES * BYTE_BITS;
   localparam int ADDR_W         = $clog2(STORE_BYTES);

   // field widths of the request and response
   localparam int OP_W   = 3;
   localparam int CNT_W  = 6;
   localparam int DATA_W = 32;
   localparam int POS_W  = 16;

   // byte window that holds every byte a field can touch
   localparam int WIN_BYTES = MAX_FIELD_BITS / BYTE_BITS + 1;
   localparam int WIN_BITS  = WIN_BYTES * BYTE_BITS;
   localparam int WIN_IDX_W = $clog2(WIN_BITS);
   localparam int BCNT_W    = $clog2(WIN_BYTES + 1);

   // request codes
   typedef enum logic [OP_W-1:0] {
      OP_READ     = 3'd0,
      OP_WRITE    = 3'd1,
      OP_SEEK     = 3'd2,
      OP_ALIGN    = 3'd3,
      OP_WRITE_AT = 3'd4
   } op_type;

endpackage

### src/bbrw_if.sv
// Valid/ready channel interfaces for the bit buffer requests and responses.
// Depends on bbrw_pkg for the field widths.
interface bbrw_req_if;
   import bbrw_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   req_type;
   logic [CNT_W-1:0]  bit_count;
   logic [DATA_W-1:0] write_data;
   logic [POS_W-1:0]  position;

   modport source (output valid, req_type, bit_count, write_data, position, input ready);
   modport sink   (input valid, req_type, bit_count, write_data, position, output ready);
endinterface

interface bbrw_rsp_if;
   import bbrw_pkg::*;

   logic              valid;
   logic              ready;
   logic              ok;
   logic [DATA_W-1:0] read_data;
   logic [POS_W-1:0]  current_pos;
   logic [POS_W-1:0]  current_len;

   modport source (output valid, ok, read_data, current_pos, current_len, input ready);
   modport sink   (input valid, ok, read_data, current_pos, current_len, output ready);
endinterface

### src/bbrw_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module bbrw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/bit_buffer_reader_writer.sv
// Top level of the bit buffer reader/writer: control sequencer around the byte store.
// Depends on bbrw_pkg, the channel interfaces in bbrw_if.sv and bbrw_ram.
//
// Bit-addressed byte store, most significant bit first within each byte, with a cursor
// and a fill length. One request is worked on at a time and every request gives one
// response. With the output register free, seek, align, unknown codes and requests that
// fail before touching the store pass from the accept through the decide and done states
// back to idle. A successful read, and a write or write-at that reaches the store (a
// write-at whose cursor restore fails included), also pass through the read and merge
// states, a write also through the write state. nbytes (1 to 5) is the number of store
// bytes the field touches: the single byte-wide store is read one byte a cycle into a
// window, the field is extracted or merged in one step, and the window is written back
// one byte a cycle. A new request is taken while the previous response still waits in
// the output register; a response is loaded only once that register is free. The store
// needs no clearing after reset; bits never written read as arbitrary values.
module bit_buffer_reader_writer (
   input  logic                     clock,
   input  logic                     reset,
   bbrw_req_if.sink                 req_chan,
   bbrw_rsp_if.source               rsp_chan,
   input  logic                     csr_write_en,
   input  logic                     csr_write_data
);
   import bbrw_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_READ,
      ST_MERGE,
      ST_WRITE,
      ST_DONE
   } state_type;

   state_type            state_ff;
   logic                 read_only_ff;
   logic [POS_W-1:0]     cursor_ff;
   logic [POS_W-1:0]     fill_ff;

   // latched request
   op_type               rq_op_ff;
   logic [CNT_W-1:0]     rq_cnt_ff;
   logic [DATA_W-1:0]    rq_data_ff;
   logic [POS_W-1:0]     rq_pos_ff;

   // store access
   logic [ADDR_W-1:0]    base_addr_ff;
   logic [2:0]           bit_ofs_ff;
   logic [BCNT_W-1:0]    nbytes_ff;
   logic [BCNT_W-1:0]    issue_ff;
   logic [BCNT_W-1:0]    capt_ff;
   logic                 rd_pend_ff;
   logic                 is_write_ff;
   logic [WIN_BITS-1:0]  window_ff;

   // staged result
   logic                 res_ok_ff;
   logic [DATA_W-1:0]    res_rdata_ff;
   logic [POS_W-1:0]     res_pos_ff;
   logic [POS_W-1:0]     res_len_ff;

   // output register
   logic                 rsp_valid_ff;
   logic                 out_ok_ff;
   logic [DATA_W-1:0]    out_rdata_ff;
   logic [POS_W-1:0]     out_pos_ff;
   logic [POS_W-1:0]     out_len_ff;

   // decision values
   logic                 cnt_good;
   logic                 w_good;
   logic [POS_W-1:0]     base;
   logic [POS_W:0]       end_pos;
   logic [POS_W:0]       grown;
   logic [POS_W:0]       aligned;
   logic [6:0]           span_sum;
   logic                 res_ok_in;
   logic [POS_W-1:0]     res_pos_in;
   logic [POS_W-1:0]     res_len_in;
   logic                 mem_rd_in;
   logic                 mem_wr_in;
   logic [BCNT_W-1:0]    nbytes_in;
   logic [ADDR_W-1:0]    base_addr_in;

   // window extract and merge
   logic [WIN_IDX_W-1:0] sh;
   logic [WIN_BITS-1:0]  fmask;
   logic [WIN_BITS-1:0]  wmask;
   logic [WIN_BITS-1:0]  win_shift;
   logic [WIN_BITS-1:0]  data_win;
   logic [WIN_BITS-1:0]  window_in;
   logic [DATA_W-1:0]    rdata_in;

   // store ports
   logic                 ram_rd_en;
   logic [ADDR_W-1:0]    ram_rd_addr;
   logic [BYTE_BITS-1:0] ram_rd_data;
   logic                 ram_wr_en;
   logic [ADDR_W-1:0]    ram_wr_addr;
   logic [BYTE_BITS-1:0] ram_wr_data;
   logic [BCNT_W-1:0]    capt_slot;
   logic [BCNT_W-1:0]    wr_slot;
   logic [WIN_IDX_W-1:0] capt_lsb;
   logic [WIN_IDX_W-1:0] wr_lsb;
   logic                 rsp_free;

   // request decision from the latched request and the current cursor and length
   always_comb begin
      cnt_good = (rq_cnt_ff != '0) && (rq_cnt_ff <= CNT_W'(MAX_FIELD_BITS));
      base     = (rq_op_ff == OP_WRITE_AT) ? rq_pos_ff : cursor_ff;
      end_pos  = {1'b0, base} + (POS_W+1)'(rq_cnt_ff);
      w_good   = !read_only_ff && cnt_good && (end_pos <= (POS_W+1)'(CAP_BITS));
      grown    = (end_pos > {1'b0, fill_ff}) ? end_pos : {1'b0, fill_ff};
      aligned  = ({1'b0, cursor_ff} + (POS_W+1)'(BYTE_MASK)) & ~((POS_W+1)'(BYTE_MASK));
      span_sum = 7'(base[2:0]) + 7'(rq_cnt_ff) + 7'(BYTE_MASK);
      nbytes_in    = BCNT_W'(span_sum >> 3);
      base_addr_in = ADDR_W'(base >> 3);

      res_ok_in  = 1'b0;
      res_pos_in = cursor_ff;
      res_len_in = fill_ff;
      mem_rd_in  = 1'b0;
      mem_wr_in  = 1'b0;

      unique case (rq_op_ff)
         OP_READ: begin
            if (cnt_good) begin
               if (end_pos <= {1'b0, fill_ff}) begin
                  res_ok_in  = 1'b1;
                  res_pos_in = end_pos[POS_W-1:0];
                  mem_rd_in  = 1'b1;
               end else if (cursor_ff < fill_ff) begin
                  // read stops at the fill length
                  res_pos_in = fill_ff;
               end
            end
         end
         OP_WRITE: begin
            if (w_good) begin
               res_ok_in  = 1'b1;
               res_pos_in = end_pos[POS_W-1:0];
               res_len_in = grown[POS_W-1:0];
               mem_wr_in  = 1'b1;
            end
         end
         OP_SEEK: begin
            if (rq_pos_ff <= fill_ff) begin
               res_ok_in  = 1'b1;
               res_pos_in = rq_pos_ff;
            end
         end
         OP_ALIGN: begin
            res_ok_in  = 1'b1;
            res_pos_in = aligned[POS_W-1:0];
         end
         OP_WRITE_AT: begin
            if (rq_pos_ff <= fill_ff) begin
               if (!w_good) begin
                  res_pos_in = rq_pos_ff;
               end else begin
                  mem_wr_in  = 1'b1;
                  res_len_in = grown[POS_W-1:0];
                  // restore fails when the old cursor lies past the new length
                  if ({1'b0, cursor_ff} <= grown) begin
                     res_ok_in  = 1'b1;
                     res_pos_in = cursor_ff;
                  end else begin
                     res_pos_in = end_pos[POS_W-1:0];
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   // field extract and merge over the byte window
   always_comb begin
      sh        = WIN_IDX_W'(WIN_BITS) - WIN_IDX_W'(bit_ofs_ff) - WIN_IDX_W'(rq_cnt_ff);
      fmask     = ~({WIN_BITS{1'b1}} << rq_cnt_ff);
      wmask     = fmask << sh;
      win_shift = window_ff >> sh;
      rdata_in  = win_shift[DATA_W-1:0] & fmask[DATA_W-1:0];
      data_win  = WIN_BITS'(rq_data_ff) & fmask;
      window_in = (window_ff & ~wmask) | (data_win << sh);
   end

   // store addressing, first byte of the span in the top slot of the window
   always_comb begin
      capt_slot   = BCNT_W'(WIN_BYTES - 1) - capt_ff;
      wr_slot     = BCNT_W'(WIN_BYTES - 1) - issue_ff;
      capt_lsb    = WIN_IDX_W'({capt_slot, 3'b000});
      wr_lsb      = WIN_IDX_W'({wr_slot, 3'b000});
      ram_rd_en   = (state_ff == ST_READ) && (issue_ff < nbytes_ff);
      ram_rd_addr = base_addr_ff + ADDR_W'(issue_ff);
      ram_wr_en   = (state_ff == ST_WRITE);
      ram_wr_addr = base_addr_ff + ADDR_W'(issue_ff);
      ram_wr_data = window_ff[wr_lsb +: BYTE_BITS];
      rsp_free    = !rsp_valid_ff || rsp_chan.ready;
   end

   bbrw_ram #(
      .WIDTH (BYTE_BITS),
      .DEPTH (STORE_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // sequencer, state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         read_only_ff <= 1'b0;
         cursor_ff    <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         issue_ff     <= '0;
         capt_ff      <= '0;
         rd_pend_ff   <= 1'b0;
      end else begin
         if (csr_write_en) begin
            read_only_ff <= csr_write_data;
         end

         // response register drains unless the sequencer reloads it this cycle
         if (rsp_valid_ff && rsp_chan.ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_chan.valid) begin
                  rq_op_ff   <= op_type'(req_chan.req_type);
                  rq_cnt_ff  <= req_chan.bit_count;
                  rq_data_ff <= req_chan.write_data;
                  rq_pos_ff  <= req_chan.position;
                  state_ff   <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               res_ok_ff    <= res_ok_in;
               res_pos_ff   <= res_pos_in;
               res_len_ff   <= res_len_in;
               res_rdata_ff <= '0;
               base_addr_ff <= base_addr_in;
               bit_ofs_ff   <= base[2:0];
               nbytes_ff    <= nbytes_in;
               is_write_ff  <= mem_wr_in;
               issue_ff     <= '0;
               capt_ff      <= '0;
               rd_pend_ff   <= 1'b0;
               if (mem_rd_in || mem_wr_in) begin
                  state_ff <= ST_READ;
               end else begin
                  state_ff <= ST_DONE;
               end
            end
            ST_READ: begin
               if (ram_rd_en) begin
                  issue_ff <= issue_ff + 1'b1;
               end
               rd_pend_ff <= ram_rd_en;
               if (rd_pend_ff) begin
                  window_ff[capt_lsb +: BYTE_BITS] <= ram_rd_data;
                  capt_ff <= capt_ff + 1'b1;
                  if (capt_ff == nbytes_ff - 1'b1) begin
                     state_ff <= ST_MERGE;
                  end
               end
            end
            ST_MERGE: begin
               issue_ff <= '0;
               if (is_write_ff) begin
                  window_ff <= window_in;
                  state_ff  <= ST_WRITE;
               end else begin
                  res_rdata_ff <= rdata_in;
                  state_ff     <= ST_DONE;
               end
            end
            ST_WRITE: begin
               issue_ff <= issue_ff + 1'b1;
               if (issue_ff == nbytes_ff - 1'b1) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  out_ok_ff    <= res_ok_ff;
                  out_rdata_ff <= res_rdata_ff;
                  out_pos_ff   <= res_pos_ff;
                  out_len_ff   <= res_len_ff;
                  cursor_ff    <= res_pos_ff;
                  fill_ff      <= res_len_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.ok          = out_ok_ff;
   assign rsp_chan.read_data   = out_rdata_ff;
   assign rsp_chan.current_pos = out_pos_ff;
   assign rsp_chan.current_len = out_len_ff;

`ifndef SYNTHESIS
   // every byte of the span is captured before the merge step
   a_span_captured: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE) |-> (capt_ff == nbytes_ff))
      else $error("merge started before the whole byte span was read");

   // store writes stay inside the byte span of the request
   a_write_in_span: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (issue_ff < nbytes_ff) && is_write_ff)
      else $error("store write outside the byte span");

   // the fill length never shrinks
   a_fill_grows: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (fill_ff >= $past(fill_ff)))
      else $error("fill length decreased");

   // a response is loaded only into a free output register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready && state_ff == ST_DONE) |=> (state_ff == ST_DONE))
      else $error("response loaded over a pending one");
`endif

endmodule
